[hdl/vcd_pkg.sv]
// ----------------------------------------------------------------------------
// vcd_pkg
// Shared types, codes and helpers for the unsigned varint codec.
// ----------------------------------------------------------------------------
package vcd_pkg;

  localparam int MAX_BYTES_DEF = 10;
  localparam int GROUP_W       = 7;
  localparam int NUM_GROUPS    = 10;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_LIMIT = 2'd2;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_RESULT = 1'b1;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } vcd_state_t;

  typedef struct packed {
    logic in_valid;
    logic mode;
    logic fits;
    logic out_free;
    logic final_byte;
  } vcd_ctl_in_t;

  typedef struct packed {
    logic ready;
    logic start_enc;
    logic enc_err;
    logic dec_step;
    logic emit;
    logic enc_phase;
  } vcd_ctl_out_t;

  // Number of 7-bit groups needed to encode v; zero still takes one byte.
  function automatic logic [3:0] group_count(input logic [63:0] v);
    logic [3:0] n;
    n = 4'd1;
    for (int g = 1; g < NUM_GROUPS; g++) begin
      if ((v >> (GROUP_W * g)) != 64'd0) n = 4'(g + 1);
    end
    return n;
  endfunction

endpackage

[hdl/vcd_shifter.sv]
// ----------------------------------------------------------------------------
// vcd_shifter
// Shared 64-bit shifter: peels a group off in encode, places a group in decode.
// ----------------------------------------------------------------------------
module vcd_shifter (
  input  logic [63:0] operand,
  input  logic [5:0]  amount,
  input  logic        left,
  output logic [63:0] result
);

  always_comb begin
    if (left) begin
      result = operand << amount;
    end else begin
      result = operand >> amount;
    end
  end

endmodule

[hdl/vcd_ctrl.sv]
// ----------------------------------------------------------------------------
// vcd_ctrl
// Sequencer for the varint codec: takes items and steps the byte emitter.
// ----------------------------------------------------------------------------
module vcd_ctrl
  import vcd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  vcd_ctl_in_t  ctl_in,
  output vcd_ctl_out_t ctl_out
);

  vcd_state_t state;
  vcd_state_t state_next;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl_out.ready     = 1'b0;
    ctl_out.emit      = 1'b0;
    ctl_out.enc_phase = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ctl_out.ready = ctl_in.out_free;
      end
      ST_EMIT: begin
        ctl_out.enc_phase = 1'b1;
        ctl_out.emit      = ctl_in.out_free;
      end
      default: begin
        ctl_out.ready = 1'b0;
      end
    endcase
    accept            = ctl_in.in_valid & ctl_out.ready;
    ctl_out.start_enc = accept & (ctl_in.mode == MODE_ENCODE) & ctl_in.fits;
    ctl_out.enc_err   = accept & (ctl_in.mode == MODE_ENCODE) & ~ctl_in.fits;
    ctl_out.dec_step  = accept & (ctl_in.mode == MODE_DECODE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (ctl_in.in_valid && ctl_in.out_free && ctl_in.mode == MODE_ENCODE && ctl_in.fits) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (ctl_in.out_free && ctl_in.final_byte) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/varint_codec.sv]
// ----------------------------------------------------------------------------
// varint_codec
// Unsigned LEB128 varint encoder and byte-at-a-time decoder.
// ----------------------------------------------------------------------------
// A decode item (tuser 1) gives a result only when its byte ends a number,
// runs out of data or hits the byte limit. An encode item (tuser 0) is sent
// out as one byte per 7-bit group (at most MAX_BYTES), and no new item is
// taken until its last byte has been emitted; an item that does not fit its
// capacity gives one error result. The single shared shifter peels one
// 7-bit group per cycle into the one-entry output register while the output
// is free; output back-pressure stalls the emission.
module varint_codec
  import vcd_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // value[63:0], capacity[67:64], byte_in[75:68], zero
  input  logic        s_tuser,   // mode
  input  logic        s_tlast,   // last_available
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // byte_out[7:0], value_out[71:8], length[75:72],
                                 // status[77:76], zero
  output logic        m_tuser,   // kind
  output logic        m_tlast    // last
);

  localparam logic [3:0] MaxB = 4'(MAX_BYTES);

  logic [63:0] in_value;
  logic [3:0]  in_cap;
  logic [7:0]  in_byte;
  logic [3:0]  cap_eff;
  logic [3:0]  need;

  logic [63:0] work;
  logic [3:0]  enc_len;
  logic [3:0]  remaining;

  logic [63:0] accumulator;
  logic [3:0]  bytes_seen;
  logic [3:0]  pos;
  logic [3:0]  n_dec;
  logic [6:0]  shamt_w;
  logic [63:0] acc_next;
  logic        dec_done;

  logic [63:0] sh_operand;
  logic [5:0]  sh_amount;
  logic [63:0] sh_result;

  logic        out_free;
  vcd_ctl_in_t  ctl_in;
  vcd_ctl_out_t ctl_out;

  assign in_value = s_tdata[63:0];
  assign in_cap   = s_tdata[67:64];
  assign in_byte  = s_tdata[75:68];

  assign cap_eff  = (in_cap > MaxB) ? MaxB : in_cap;
  assign need     = group_count(in_value);
  assign out_free = ~m_tvalid | m_tready;

  assign ctl_in.in_valid   = s_tvalid;
  assign ctl_in.mode       = s_tuser;
  assign ctl_in.fits       = (need <= cap_eff);
  assign ctl_in.out_free   = out_free;
  assign ctl_in.final_byte = (remaining == 4'd1);

  vcd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_in),
    .ctl_out (ctl_out)
  );

  assign s_tready = ctl_out.ready;

  // The shifter drops the emitted group while encoding and places the new
  // group at its position while decoding.
  assign pos     = (bytes_seen >= MaxB) ? 4'd0 : bytes_seen;
  assign shamt_w = {pos, 3'b000} - {3'b000, pos};
  assign n_dec   = pos + 4'd1;

  assign sh_operand = ctl_out.enc_phase ? work : {57'd0, in_byte[6:0]};
  assign sh_amount  = ctl_out.enc_phase ? 6'(GROUP_W) : shamt_w[5:0];

  vcd_shifter u_shifter (
    .operand (sh_operand),
    .amount  (sh_amount),
    .left    (~ctl_out.enc_phase),
    .result  (sh_result)
  );

  assign acc_next = accumulator + sh_result;
  assign dec_done = ~in_byte[7] | (n_dec >= MaxB) | s_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= 64'd0;
      bytes_seen  <= 4'd0;
      remaining   <= 4'd0;
    end else begin
      if (ctl_out.dec_step) begin
        if (dec_done) begin
          accumulator <= 64'd0;
          bytes_seen  <= 4'd0;
        end else begin
          accumulator <= acc_next;
          bytes_seen  <= n_dec;
        end
      end
      if (ctl_out.start_enc) begin
        remaining <= need;
      end else if (ctl_out.emit) begin
        remaining <= remaining - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_out.start_enc) begin
      work    <= in_value;
      enc_len <= need;
    end else if (ctl_out.emit) begin
      work <= sh_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= ctl_out.enc_err | ctl_out.emit | (ctl_out.dec_step & dec_done);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_out.emit) begin
      m_tuser <= KIND_BYTE;
      m_tlast <= (remaining == 4'd1);
      m_tdata <= {2'b00, STATUS_OK, enc_len, 64'd0,
                  (sh_result != 64'd0), work[6:0]};
    end else if (ctl_out.enc_err) begin
      m_tuser <= KIND_RESULT;
      m_tlast <= 1'b1;
      m_tdata <= {2'b00, STATUS_SHORT, 4'd0, 64'd0, 8'd0};
    end else if (ctl_out.dec_step && dec_done) begin
      m_tuser <= KIND_RESULT;
      m_tlast <= 1'b1;
      if (!in_byte[7]) begin
        m_tdata <= {2'b00, STATUS_OK, n_dec, acc_next, 8'd0};
      end else if (n_dec >= MaxB) begin
        m_tdata <= {2'b00, STATUS_LIMIT, n_dec, 64'd0, 8'd0};
      end else begin
        m_tdata <= {2'b00, STATUS_SHORT, n_dec, 64'd0, 8'd0};
      end
    end
  end

`ifndef SYNTH
  // A partial number never reaches the byte limit.
  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_seen < MaxB)
    else $error("bytes_seen reached the byte limit");

  // No item is taken while encoded bytes are still being emitted.
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    ctl_out.enc_phase |-> !s_tready)
    else $error("item accepted during byte emission");

  // The closing encoded byte has no continuation bit, the others do.
  a_cont_bit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_BYTE) |-> (m_tdata[7] == !m_tlast))
    else $error("continuation bit does not match last flag");

  // An encoded run lasts exactly as many bytes as its length field.
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    ctl_out.start_enc |=> (remaining == enc_len))
    else $error("emit counter does not match encoded length");
`endif

endmodule

[bench/varint_checker.sv]
// ----------------------------------------------------------------------------
// varint_checker
// Watches both streams of the varint codec and predicts every result from the
// accepted items. Each accepted result is compared field by field with the
// oldest prediction, and failures are counted for the bench top.
// ----------------------------------------------------------------------------
module varint_checker
  import vcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,   // value[63:0], capacity[67:64], byte_in[75:68], zero
  input  logic        s_tuser,   // mode
  input  logic        s_tlast,   // last_available
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,   // byte_out[7:0], value_out[71:8], length[75:72],
                                 // status[77:76], zero
  input  logic        m_tuser,   // kind
  input  logic        m_tlast,   // last
  output int          fail_count,
  output int          results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        kind;
    logic [7:0]  byte_out;
    logic [63:0] value_out;
    logic [3:0]  length;
    logic [1:0]  status;
    logic        last;
  } codec_res_t;

  codec_res_t  codec_results_q[$];
  logic [63:0] dec_acc;
  logic [3:0]  dec_count;

  task automatic encode_value(input logic [63:0] v, input logic [3:0] cap);
    logic [3:0]  eff_cap;
    logic [3:0]  need;
    logic [63:0] rest;
    codec_res_t  r;
    eff_cap = (cap > MAX_BYTES_DEF) ? 4'(MAX_BYTES_DEF) : cap;
    need = 4'd1;
    rest = v >> 7;
    while (rest != 64'd0) begin
      need++;
      rest = rest >> 7;
    end
    r = '0;
    if (need > eff_cap) begin
      r.kind   = KIND_RESULT;
      r.status = STATUS_SHORT;
      r.last   = 1'b1;
      codec_results_q.push_back(r);
    end else begin
      for (int i = 0; i < need; i++) begin
        r.kind     = KIND_BYTE;
        r.byte_out = {((v >> 7) != 64'd0), v[6:0]};
        r.length   = need;
        r.status   = STATUS_OK;
        r.last     = (i == need - 1);
        codec_results_q.push_back(r);
        v = v >> 7;
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic lastav);
    logic [3:0] pos;
    logic [3:0] n;
    codec_res_t r;
    pos = (dec_count >= MAX_BYTES_DEF) ? 4'd0 : dec_count;
    // Groups that would land above bit 63 fall off the top here.
    dec_acc = dec_acc + ({57'd0, b[6:0]} << (7 * pos));
    n = pos + 4'd1;
    r = '0;
    r.kind   = KIND_RESULT;
    r.length = n;
    r.last   = 1'b1;
    if (!b[7]) begin
      r.value_out = dec_acc;
      r.status    = STATUS_OK;
    end else if (n >= MAX_BYTES_DEF) begin
      r.status = STATUS_LIMIT;
    end else if (lastav) begin
      r.status = STATUS_SHORT;
    end else begin
      dec_count = n;
      return;
    end
    codec_results_q.push_back(r);
    dec_acc   = '0;
    dec_count = '0;
  endtask

  always @(posedge clk) begin
    codec_res_t got;
    codec_res_t want;
    if (rst) begin
      codec_results_q.delete();
      dec_acc   = '0;
      dec_count = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.kind      = m_tuser;
        got.byte_out  = m_tdata[7:0];
        got.value_out = m_tdata[71:8];
        got.length    = m_tdata[75:72];
        got.status    = m_tdata[77:76];
        got.last      = m_tlast;
        if (codec_results_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result kind %0d byte %02h value %016h",
                     $realtime, got.kind, got.byte_out, got.value_out,
                     " len %0d st %0d last %0d", got.length, got.status, got.last);
          fail_count++;
        end else begin
          want = codec_results_q.pop_front();
          if (got.kind !== want.kind || got.byte_out !== want.byte_out ||
              got.value_out !== want.value_out || got.length !== want.length ||
              got.status !== want.status || got.last !== want.last) begin
            if (fail_count < 10) begin
              $display("%0t: expected kind %0d byte %02h value %016h len %0d st %0d last %0d",
                       $realtime, want.kind, want.byte_out, want.value_out, want.length,
                       want.status, want.last);
              $display("%0t:      got kind %0d byte %02h value %016h len %0d st %0d last %0d",
                       $realtime, got.kind, got.byte_out, got.value_out, got.length,
                       got.status, got.last);
            end
            fail_count++;
          end
        end
      end
      // A result can never stem from an item taken at the same edge, so the
      // prediction for a new item is queued after the compare.
      if (s_tvalid && s_tready) begin
        if (s_tuser == MODE_ENCODE)
          encode_value(s_tdata[63:0], s_tdata[67:64]);
        else
          decode_byte(s_tdata[75:68], s_tlast);
      end
    end
    results_due = codec_results_q.size();
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the varint codec. Directed encode and decode items
// cover the edge cases, then random values, well-formed byte sequences and
// broken ones follow, sent in bursts against a stalling receiver.
// ----------------------------------------------------------------------------
module testbench;
  import vcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 80;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_PERIODIC
  } ready_mode_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int fail_count;
  int results_due;
  int burst_left = 0;
  int sent_items = 0;
  int cycle_cnt  = 0;

  ready_mode_t ready_mode = RDY_ALWAYS;
  int          ready_left = 0;
  int          ready_tick = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  varint_codec i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  varint_checker i_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // The receiver switches between random stall patterns.
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_left = $urandom_range(20, 80);
    end
    ready_left--;
    ready_tick++;
    case (ready_mode)
      RDY_ALWAYS:   m_tready <= 1'b1;
      RDY_COIN:     m_tready <= 1'($urandom_range(0, 1));
      RDY_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
      RDY_PERIODIC: m_tready <= (ready_tick % 5 >= 2);
    endcase
  end

  task automatic send_item(input logic mode, input logic [63:0] value,
                           input logic [3:0] cap, input logic [7:0] b,
                           input logic lastav);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tlast  <= lastav;
    s_tdata  <= {4'd0, b, cap, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    sent_items++;
  endtask

  // The unused fields of each item carry random filler.
  task automatic enc(input logic [63:0] value, input logic [3:0] cap);
    send_item(MODE_ENCODE, value, cap, 8'($urandom), 1'($urandom));
  endtask

  task automatic dec(input logic [7:0] b, input logic lastav);
    send_item(MODE_DECODE, {$urandom, $urandom}, 4'($urandom), b, lastav);
  endtask

  // Holds the sender off until every predicted result has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    wait (results_due == 0);
    @(negedge clk);
    burst_left = 0;
  endtask

  function automatic logic [63:0] rand_value();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 64'd0;
    if (pick == 1) return '1;
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  function automatic logic [3:0] rand_cap();
    if ($urandom_range(0, 1) == 0) return 4'($urandom_range(10, 15));
    return 4'($urandom_range(0, 9));
  endfunction

  // One number as a byte sequence. A terminated number clears bit 7 on its
  // final byte; an open one keeps it set and so runs out of data or into
  // the byte limit.
  task automatic send_number(input int len, input logic terminated);
    for (int k = 0; k < len; k++) begin
      logic [7:0] b;
      logic       lastav;
      b[6:0] = 7'($urandom_range(0, 127));
      b[7]   = (k < len - 1) || !terminated;
      if (k < len - 1)
        lastav = 1'b0;
      else if (terminated || len >= MAX_BYTES_DEF)
        lastav = 1'($urandom);
      else
        lastav = 1'b1;
      dec(b, lastav);
      if (terminated && k < len - 1 && $urandom_range(0, 9) == 0)
        enc(rand_value(), rand_cap());
    end
  endtask

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int directed_cnt;
    int next_pause;
    int pick;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    enc(64'd0, 4'd1);
    enc(64'd0, 4'd0);
    enc(64'd128, 4'd1);
    enc(64'd128, 4'd2);
    enc('1, 4'd15);
    enc('1, 4'd9);
    dec(8'h00, 1'b0);
    dec(8'hFF, 1'b1);
    // An encode item in the middle of a number must not disturb it.
    dec(8'h80, 1'b0);
    enc(64'h8000_0000_0000_0000, 4'd10);
    dec(8'h01, 1'b0);
    // Ten continuing bytes hit the limit, even with the data marked as done.
    repeat (MAX_BYTES_DEF - 1) dec(8'hFF, 1'b0);
    dec(8'hFF, 1'b1);
    drain();

    directed_cnt = sent_items;
    next_pause = sent_items + 30;
    while (sent_items < directed_cnt + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)
        enc(rand_value(), rand_cap());
      else if (pick < 80)
        send_number(($urandom_range(0, 3) == 0) ? MAX_BYTES_DEF : $urandom_range(1, 9),
                    1'b1);
      else if (pick < 90)
        send_number($urandom_range(1, MAX_BYTES_DEF), 1'b0);
      else
        dec(8'($urandom), ($urandom_range(0, 3) == 0));
      if (sent_items >= next_pause) begin
        drain();
        next_pause = sent_items + 30;
      end
    end

    drain();
    repeat (24) @(posedge clk);
    if (fail_count == 0 && results_due == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[filelist.f]
hdl/vcd_pkg.sv
hdl/vcd_shifter.sv
hdl/vcd_ctrl.sv
hdl/varint_codec.sv
bench/varint_checker.sv
bench/testbench.sv
